// ===== hw/rtl/first_fit_block_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// First-fit block allocator assertion macros
// Shared property templates for the allocator's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFBA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// First-fit block allocator package
// Widths, codes, shared types and the table reserve function.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int MAX_BLOCKS  = 64;
	localparam int ENTRY_BYTES = 16;
	localparam int IDX_W       = $clog2(MAX_BLOCKS);
	localparam int CNT_W       = IDX_W + 1;
	localparam int RES_W       = $clog2(ENTRY_BYTES * (MAX_BLOCKS + 1) + 1);

	localparam int ADDR_W = 32;
	localparam int LOC_W  = ADDR_W + 1;
	localparam int TMP_W  = ADDR_W + 2;
	localparam int SUM_W  = ADDR_W + 3;
	localparam int CFG_IDX_W = 1;

	localparam logic [LOC_W-1:0] REGION_TOP = LOC_W'(1) << ADDR_W;

	localparam logic [1:0] ST_GRANT    = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_BYTES = 1'd1;

	typedef struct packed {
		logic [TMP_W-1:0]  a;
		logic [ADDR_W-1:0] b;
		logic [TMP_W-1:0]  c;
	} alu_req_t;

	typedef struct packed {
		logic [IDX_W-1:0]  raddr;
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [ADDR_W-1:0] wstart;
		logic [ADDR_W-1:0] wlen;
	} tbl_req_t;

	typedef struct packed {
		logic             busy;
		logic [CNT_W-1:0] count;
	} ctrl_stat_t;

	// Table space that must stay free above the blocks once one more entry is added.
	function automatic logic [RES_W-1:0] reserve_bytes(input logic [CNT_W-1:0] cnt);
		logic [RES_W-1:0] slots;
		slots = RES_W'(cnt) + RES_W'(2);
		return RES_W'(slots * RES_W'(ENTRY_BYTES));
	endfunction

endpackage

// ===== hw/rtl/ffba_alu.sv =====
// ----------------------------------------------------------------------------
// Shared add and compare unit
// Forms a + b and tests the sum against a bound c.
// ----------------------------------------------------------------------------
module ffba_alu (
	input  ffba_pkg::alu_req_t         req,
	output logic [ffba_pkg::SUM_W-1:0] sum,
	output logic                       le
);
	import ffba_pkg::*;

	assign sum = SUM_W'(req.a) + SUM_W'(req.b);
	assign le  = (sum <= SUM_W'(req.c));

endmodule

// ===== hw/rtl/ffba_table.sv =====
// ----------------------------------------------------------------------------
// Block table memory
// Start and length of each allocated block, one write and one registered read.
// ----------------------------------------------------------------------------
module ffba_table (
	input  logic                        clk,
	input  ffba_pkg::tbl_req_t          req,
	output logic [ffba_pkg::ADDR_W-1:0] rstart,
	output logic [ffba_pkg::ADDR_W-1:0] rlen
);
	import ffba_pkg::*;

	logic [ADDR_W-1:0] start_mem [MAX_BLOCKS];
	logic [ADDR_W-1:0] len_mem   [MAX_BLOCKS];
	logic [ADDR_W-1:0] rstart_q;
	logic [ADDR_W-1:0] rlen_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			start_mem[req.waddr] <= req.wstart;
			len_mem[req.waddr]   <= req.wlen;
		end
		rstart_q <= start_mem[req.raddr];
		rlen_q   <= len_mem[req.raddr];
	end

	assign rstart = rstart_q;
	assign rlen   = rlen_q;

endmodule

// ===== hw/rtl/ffba_ctrl.sv =====
// ----------------------------------------------------------------------------
// Allocator sequencer
// Walks the table with the shared unit, then shifts and inserts the new entry.
// ----------------------------------------------------------------------------
module ffba_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ffba_pkg::ADDR_W-1:0]   request_size,
	input  logic [ffba_pkg::ADDR_W-1:0]   region_base,
	input  logic [ffba_pkg::ADDR_W-1:0]   region_bytes,
	input  logic [ffba_pkg::SUM_W-1:0]    alu_sum,
	input  logic                          alu_le,
	input  logic [ffba_pkg::ADDR_W-1:0]   rstart,
	input  logic [ffba_pkg::ADDR_W-1:0]   rlen,
	output ffba_pkg::alu_req_t            alu_req,
	output ffba_pkg::tbl_req_t            tbl_req,
	output ffba_pkg::ctrl_stat_t          stat,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [ffba_pkg::ADDR_W-1:0]   grant_address
);
	import ffba_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_RE, S_LAST_ADDR, S_LAST_SUM, S_LAST_FIT, S_ENT_GAP, S_ENT_STEP,
		S_END_SUM, S_END_FIT, S_INS_RD, S_INS_WR, S_INS_FIN
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  pos_q;
	logic [IDX_W-1:0]  j_q;
	logic              done_q;
	logic [1:0]        status_q;
	logic [ADDR_W-1:0] grant_q;

	logic [ADDR_W-1:0] size_q;
	logic [LOC_W-1:0]  loc_q;
	logic [TMP_W-1:0]  tmp_q;
	logic [LOC_W-1:0]  rend_q;
	logic              lastfit_q;

	logic [RES_W-1:0]  reserve;
	logic [LOC_W-1:0]  rend_d;
	logic [IDX_W-1:0]  last_idx;
	logic [IDX_W-1:0]  cnt_idx;

	assign reserve  = reserve_bytes(cnt_q);
	assign last_idx = IDX_W'(cnt_q - CNT_W'(1));
	assign cnt_idx  = cnt_q[IDX_W-1:0];
	assign rend_d   = (alu_sum[ADDR_W] && (alu_sum[ADDR_W-1:0] != '0)) ?
	                  REGION_TOP : alu_sum[LOC_W-1:0];

	always_comb begin
		alu_req        = '0;
		tbl_req.raddr  = idx_q;
		tbl_req.we     = 1'b0;
		tbl_req.waddr  = j_q;
		tbl_req.wstart = rstart;
		tbl_req.wlen   = rlen;
		case (state_q)
			S_RE: begin
				alu_req.a = TMP_W'(region_base);
				alu_req.b = region_bytes;
			end
			S_LAST_SUM: begin
				alu_req.a = TMP_W'(rstart);
				alu_req.b = rlen;
			end
			S_LAST_FIT: begin
				alu_req.a     = tmp_q;
				alu_req.b     = ADDR_W'(reserve);
				alu_req.c     = TMP_W'(rend_q);
				tbl_req.raddr = '0;
			end
			S_ENT_GAP: begin
				alu_req.a = TMP_W'(loc_q);
				alu_req.b = size_q;
				alu_req.c = TMP_W'(rstart);
			end
			S_ENT_STEP: begin
				alu_req.a     = TMP_W'(rstart);
				alu_req.b     = rlen;
				tbl_req.raddr = idx_q + IDX_W'(1);
			end
			S_END_SUM: begin
				alu_req.a = TMP_W'(loc_q);
				alu_req.b = size_q;
			end
			S_END_FIT: begin
				alu_req.a = tmp_q;
				alu_req.b = ADDR_W'(reserve);
				alu_req.c = TMP_W'(rend_q);
			end
			S_INS_RD: begin
				tbl_req.raddr = j_q - IDX_W'(1);
			end
			S_INS_WR: begin
				tbl_req.raddr = j_q - IDX_W'(2);
				tbl_req.we    = 1'b1;
			end
			S_INS_FIN: begin
				tbl_req.we     = 1'b1;
				tbl_req.waddr  = pos_q;
				tbl_req.wstart = loc_q[ADDR_W-1:0];
				tbl_req.wlen   = size_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			idx_q    <= '0;
			pos_q    <= '0;
			j_q      <= '0;
			done_q   <= 1'b0;
			status_q <= ST_GRANT;
			grant_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (cnt_q == CNT_W'(MAX_BLOCKS)) begin
							done_q   <= 1'b1;
							status_q <= ST_FULL;
							grant_q  <= '0;
						end else begin
							state_q <= S_RE;
						end
					end
				end
				S_RE: begin
					if (cnt_q == '0) begin
						state_q <= S_END_SUM;
					end else begin
						idx_q   <= last_idx;
						state_q <= S_LAST_ADDR;
					end
				end
				S_LAST_ADDR: begin
					state_q <= S_LAST_SUM;
				end
				S_LAST_SUM: begin
					state_q <= S_LAST_FIT;
				end
				S_LAST_FIT: begin
					idx_q   <= '0;
					state_q <= S_ENT_GAP;
				end
				S_ENT_GAP: begin
					if (alu_le && lastfit_q) begin
						pos_q   <= idx_q;
						j_q     <= cnt_idx;
						state_q <= (cnt_idx == idx_q) ? S_INS_FIN : S_INS_RD;
					end else begin
						state_q <= S_ENT_STEP;
					end
				end
				S_ENT_STEP: begin
					if (idx_q == last_idx) begin
						state_q <= S_END_SUM;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_ENT_GAP;
					end
				end
				S_END_SUM: begin
					state_q <= S_END_FIT;
				end
				S_END_FIT: begin
					if (alu_le && !loc_q[ADDR_W]) begin
						pos_q   <= cnt_idx;
						j_q     <= cnt_idx;
						state_q <= S_INS_FIN;
					end else begin
						done_q   <= 1'b1;
						status_q <= ST_NO_SPACE;
						grant_q  <= '0;
						state_q  <= S_IDLE;
					end
				end
				S_INS_RD: begin
					state_q <= S_INS_WR;
				end
				S_INS_WR: begin
					j_q <= j_q - IDX_W'(1);
					if ((j_q - IDX_W'(1)) == pos_q) begin
						state_q <= S_INS_FIN;
					end
				end
				S_INS_FIN: begin
					cnt_q    <= cnt_q + CNT_W'(1);
					done_q   <= 1'b1;
					status_q <= ST_GRANT;
					grant_q  <= loc_q[ADDR_W-1:0];
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					size_q <= request_size;
					loc_q  <= LOC_W'(region_base);
				end
			end
			S_RE: begin
				rend_q <= rend_d;
			end
			S_LAST_SUM: begin
				tmp_q <= alu_sum[TMP_W-1:0];
			end
			S_LAST_FIT: begin
				lastfit_q <= alu_le;
			end
			S_ENT_STEP: begin
				loc_q <= alu_sum[LOC_W-1:0];
			end
			S_END_SUM: begin
				tmp_q <= alu_sum[TMP_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign stat.busy     = (state_q != S_IDLE);
	assign stat.count    = cnt_q;
	assign done          = done_q;
	assign status        = status_q;
	assign grant_address = grant_q;

endmodule

// ===== hw/rtl/first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// First-fit block allocator
// Grants blocks from a managed region by a first-fit walk of a sorted table.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The single add and
// compare unit is used twice per visited entry, and on insertion the table,
// with one read and one write per cycle, moves one later entry per cycle. A
// full table answers in the cycle right after the transfer. The result appears
// for exactly one cycle with done high and must be captured then, since the
// receiver cannot stall it; busy is already low in that cycle. Configuration
// writes are taken at any edge with cfg_we high and must only be issued while
// the block is idle.
module first_fit_block_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [ffba_pkg::ADDR_W-1:0]    request_size,
	output logic                           done,
	output logic [1:0]                     status,
	output logic [ffba_pkg::ADDR_W-1:0]    grant_address,
	input  logic                           cfg_we,
	input  logic [ffba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ffba_pkg::ADDR_W-1:0]    cfg_data
);
	import ffba_pkg::*;
	`include "first_fit_block_allocator_defines.svh"

	logic [ADDR_W-1:0] region_base_q;
	logic [ADDR_W-1:0] region_bytes_q;
	alu_req_t          alu_req;
	logic [SUM_W-1:0]  alu_sum;
	logic              alu_le;
	tbl_req_t          tbl_req;
	logic [ADDR_W-1:0] rstart;
	logic [ADDR_W-1:0] rlen;
	ctrl_stat_t        stat;
	logic              table_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_base_q  <= 32'h0060_0000;
			region_bytes_q <= 32'd100000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REGION_BASE:  region_base_q  <= cfg_data;
				REG_REGION_BYTES: region_bytes_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	ffba_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.request_size  (request_size),
		.region_base   (region_base_q),
		.region_bytes  (region_bytes_q),
		.alu_sum       (alu_sum),
		.alu_le        (alu_le),
		.rstart        (rstart),
		.rlen          (rlen),
		.alu_req       (alu_req),
		.tbl_req       (tbl_req),
		.stat          (stat),
		.done          (done),
		.status        (status),
		.grant_address (grant_address)
	);

	ffba_alu u_alu (
		.req (alu_req),
		.sum (alu_sum),
		.le  (alu_le)
	);

	ffba_table u_table (
		.clk    (clk),
		.req    (tbl_req),
		.rstart (rstart),
		.rlen   (rlen)
	);

	assign busy       = stat.busy;
	assign table_full = (stat.count == CNT_W'(MAX_BLOCKS));

	`FFBA_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")
	`FFBA_ASSERT_NEXT(a_accept_busy, start && !busy && !table_full, busy, "request did not start")
	`FFBA_ASSERT_NOW(a_fail_zero, done && (status != ST_GRANT), grant_address == '0, "address on fail")
	`FFBA_ASSERT_NOW(a_full_count, done && (status == ST_FULL), table_full, "full with free entries")

endmodule
